// ===== rtl/acpi_resource_descriptor_parser_core_assert.svh =====
// Assertion macros for the resource descriptor parser core.
// Depends on nothing; the including module provides clk and arst_n.
`ifndef ACPI_RESOURCE_DESCRIPTOR_PARSER_CORE_ASSERT_SVH
`define ACPI_RESOURCE_DESCRIPTOR_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define ARDP_CHECK(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define ARDP_CHECK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/ardp_pkg.sv =====
// Shared types, codes and constants for the resource descriptor parser.
// Used by acpi_resource_descriptor_parser_core and its testbench.
`timescale 1ns / 1ps

package ardp_pkg;

	localparam int MAX_IRQS_DEF = 16;

	localparam logic [7:0] END_TAG     = 8'h79;
	localparam logic [6:0] ITEM_MEM    = 7'h06;
	localparam logic [6:0] ITEM_IRQ    = 7'h09;
	localparam logic [6:0] ITEM_END    = 7'h0F;
	localparam logic [15:0] MEM_LEN    = 16'd9;
	localparam logic [15:0] IRQ_MIN_LEN = 16'd2;

	typedef enum logic [2:0] {
		PH_TAG,
		PH_LLO,
		PH_LHI,
		PH_LPAY,
		PH_SPAY,
		PH_STOP
	} phase_t;

	typedef enum logic [1:0] {
		SQ_RUN,
		SQ_READ,
		SQ_ENTRY,
		SQ_DONE
	} seq_t;

	typedef enum logic [2:0] {
		K_MEM32,
		K_IRQ_HDR,
		K_IRQ_ENTRY,
		K_UNKNOWN,
		K_SMALL,
		K_END,
		K_DONE
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [6:0]  item;
		logic [15:0] len;
		logic [7:0]  attr;
		logic [7:0]  count;
		logic [31:0] word_a;
		logic [31:0] word_b;
		logic        trunc;
		logic        ovf;
		logic        run_end;
	} rec_t;

	function automatic rec_t mk_rec(input kind_t kind, input logic [6:0] item,
		input logic [15:0] len, input logic [7:0] attr, input logic [7:0] count,
		input logic [31:0] word_a, input logic [31:0] word_b, input logic trunc,
		input logic ovf, input logic run_end);
		rec_t r;
		r.kind    = kind;
		r.item    = item;
		r.len     = len;
		r.attr    = attr;
		r.count   = count;
		r.word_a  = word_a;
		r.word_b  = word_b;
		r.trunc   = trunc;
		r.ovf     = ovf;
		r.run_end = run_end;
		return r;
	endfunction

endpackage

// ===== rtl/ardp_irq_store.sv =====
// Store for the IRQ numbers of one Extended IRQ descriptor.
// Single write port, one read port with registered data; no package needed.
`timescale 1ns / 1ps

module ardp_irq_store #(
	parameter int DEPTH  = 16,
	parameter int ADDR_W = 4
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [31:0]       wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [31:0]       rd_data
);

	logic [31:0] mem_q [DEPTH];
	logic [31:0] rd_data_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_s1;

endmodule

// ===== rtl/acpi_resource_descriptor_parser_core.sv =====
// Top level of the resource-template descriptor parser.
// Depends on ardp_pkg, ardp_irq_store and the assertion macro header.
`timescale 1ns / 1ps
//
//   Channel   Handshake             Payload
//   input     in_valid / in_ready   data_byte, final_byte
//   output    out_valid / out_ready record_kind .. run_end (none, one or more records per word)
//
// One input word is taken per cycle while the output register can drain.
// A completed Extended IRQ descriptor with stored entries holds the input for
// the first store read and while its entries leave the store's read port, one
// per cycle while the output can drain. A final byte that follows records holds
// the input for the done record. arst_n clears the parser and sequencer state;
// the IRQ store needs no clearing pass as entries are read only after written.
// A stalled output holds its record and closes the input until it is taken.

`include "acpi_resource_descriptor_parser_core_assert.svh"

module acpi_resource_descriptor_parser_core #(
	parameter int MAX_IRQS = ardp_pkg::MAX_IRQS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        final_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  record_kind,
	output logic [6:0]  item_code,
	output logic [15:0] desc_length,
	output logic [7:0]  attr_byte,
	output logic [7:0]  irq_total,
	output logic [31:0] word_a,
	output logic [31:0] word_b,
	output logic        truncated,
	output logic        irq_overflow,
	output logic        run_end
);

	localparam int FILL_W = $clog2(MAX_IRQS + 1);
	localparam int IDX_W  = (MAX_IRQS > 1) ? $clog2(MAX_IRQS) : 1;

	// Parser state, updated only when a word is accepted.
	ardp_pkg::phase_t phase_q, phase_d;
	logic [6:0]  cur_item_q, cur_item_d;
	logic [15:0] cur_size_q, cur_size_d;
	logic [15:0] pos_q, pos_d;
	logic [7:0]  attr_q, attr_d;
	logic [7:0]  count_q, count_d;
	logic [31:0] base_q, base_d;
	logic [31:0] span_q, span_d;
	logic [FILL_W-1:0] irq_fill_q, irq_fill_d;
	logic        ovf_q, ovf_d;

	// Record sequencer and output register.
	ardp_pkg::seq_t seq_q, seq_d;
	logic [IDX_W-1:0] rd_idx_q, rd_idx_d;
	logic        fin_pend_q, fin_pend_d;
	logic        out_valid_q;
	ardp_pkg::rec_t out_q;

	// Combinational results of parsing the current word.
	ardp_pkg::rec_t rec1;
	logic        rec1_vld;
	logic        burst;
	logic        trunc_now;
	logic        is_mem, is_irq;
	logic [15:0] pos_inc, pos_m2, size_hi;
	logic [1:0]  lane;
	logic        irq_wr_en;
	logic [31:0] irq_wr_data;

	logic        out_free, accept, load, entry_last;
	ardp_pkg::rec_t load_rec;
	logic        rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic [31:0] rd_data;

	assign is_mem  = (cur_item_q == ardp_pkg::ITEM_MEM) && (cur_size_q == ardp_pkg::MEM_LEN);
	assign is_irq  = (cur_item_q == ardp_pkg::ITEM_IRQ) && (cur_size_q >= ardp_pkg::IRQ_MIN_LEN);
	assign pos_inc = pos_q + 16'd1;
	assign pos_m2  = pos_q - 16'd2;
	assign size_hi = {data_byte, cur_size_q[7:0]};
	// Memory32Fixed base bytes sit at positions 1-4 and span bytes at 5-8,
	// so both map to lane (pos - 1) mod 4.
	assign lane    = pos_q[1:0] - 2'd1;
	assign irq_wr_data = {data_byte, span_q[23:0]};

	always_comb begin
		phase_d    = phase_q;
		cur_item_d = cur_item_q;
		cur_size_d = cur_size_q;
		pos_d      = pos_q;
		attr_d     = attr_q;
		count_d    = count_q;
		base_d     = base_q;
		span_d     = span_q;
		irq_fill_d = irq_fill_q;
		ovf_d      = ovf_q;
		rec1       = '0;
		rec1_vld   = 1'b0;
		burst      = 1'b0;
		irq_wr_en  = 1'b0;
		trunc_now  = 1'b0;

		case (phase_q)
			ardp_pkg::PH_TAG: begin
				if (data_byte == ardp_pkg::END_TAG) begin
					rec1_vld = 1'b1;
					rec1 = ardp_pkg::mk_rec(ardp_pkg::K_END, ardp_pkg::ITEM_END, 16'd1,
						8'd0, 8'd0, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0);
					phase_d = ardp_pkg::PH_STOP;
				end else if (data_byte[7]) begin
					cur_item_d = data_byte[6:0];
					cur_size_d = '0;
					pos_d      = '0;
					attr_d     = '0;
					count_d    = '0;
					base_d     = '0;
					span_d     = '0;
					irq_fill_d = '0;
					ovf_d      = 1'b0;
					phase_d    = ardp_pkg::PH_LLO;
				end else begin
					cur_item_d = {3'b000, data_byte[6:3]};
					cur_size_d = {13'd0, data_byte[2:0]};
					pos_d      = '0;
					if (data_byte[2:0] == 3'd0) begin
						rec1_vld = 1'b1;
						rec1 = ardp_pkg::mk_rec(ardp_pkg::K_SMALL, {3'b000, data_byte[6:3]},
							16'd0, 8'd0, 8'd0, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0);
					end else begin
						phase_d = ardp_pkg::PH_SPAY;
					end
				end
			end
			ardp_pkg::PH_LLO: begin
				cur_size_d = {8'd0, data_byte};
				phase_d    = ardp_pkg::PH_LHI;
			end
			ardp_pkg::PH_LHI: begin
				cur_size_d = size_hi;
				if (size_hi == 16'd0) begin
					// An empty large descriptor can match neither decoded item.
					rec1_vld = 1'b1;
					rec1 = ardp_pkg::mk_rec(ardp_pkg::K_UNKNOWN, cur_item_q, 16'd0,
						8'd0, 8'd0, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0);
					phase_d = ardp_pkg::PH_TAG;
				end else begin
					phase_d = ardp_pkg::PH_LPAY;
				end
			end
			ardp_pkg::PH_LPAY: begin
				if (is_mem) begin
					if (pos_q == 16'd0) begin
						attr_d = data_byte;
					end else if (pos_q <= 16'd4) begin
						base_d[{lane, 3'b000} +: 8] = data_byte;
					end else if (pos_q <= 16'd8) begin
						span_d[{lane, 3'b000} +: 8] = data_byte;
					end
				end else if (is_irq) begin
					if (pos_q == 16'd0) begin
						attr_d = data_byte;
					end else if (pos_q == 16'd1) begin
						count_d = data_byte;
					end else begin
						// IRQ words are assembled in span_q, low byte first.
						if (pos_m2[1:0] == 2'd0) begin
							span_d = {24'd0, data_byte};
						end else begin
							span_d[{pos_m2[1:0], 3'b000} +: 8] = data_byte;
						end
						if ((pos_m2[1:0] == 2'd3) && (pos_m2[15:2] < {6'd0, count_q})) begin
							if (irq_fill_q < FILL_W'(MAX_IRQS)) begin
								irq_wr_en  = 1'b1;
								irq_fill_d = irq_fill_q + FILL_W'(1);
							end else begin
								ovf_d = 1'b1;
							end
						end
					end
				end
				pos_d = pos_inc;
				if (pos_inc == cur_size_q) begin
					rec1_vld = 1'b1;
					phase_d  = ardp_pkg::PH_TAG;
					if (is_mem) begin
						rec1 = ardp_pkg::mk_rec(ardp_pkg::K_MEM32, cur_item_q, cur_size_q,
							attr_d, 8'd0, base_d, span_d, 1'b0, 1'b0, 1'b0);
					end else if (is_irq) begin
						rec1 = ardp_pkg::mk_rec(ardp_pkg::K_IRQ_HDR, cur_item_q, cur_size_q,
							attr_d, count_d, 32'd0, 32'd0, 1'b0, ovf_d, 1'b0);
						burst = (irq_fill_d != '0);
					end else begin
						rec1 = ardp_pkg::mk_rec(ardp_pkg::K_UNKNOWN, cur_item_q, cur_size_q,
							8'd0, 8'd0, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0);
					end
				end
			end
			ardp_pkg::PH_SPAY: begin
				pos_d = pos_inc;
				if (pos_inc >= cur_size_q) begin
					rec1_vld = 1'b1;
					rec1 = ardp_pkg::mk_rec(ardp_pkg::K_SMALL, cur_item_q, cur_size_q,
						8'd0, 8'd0, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0);
					phase_d = ardp_pkg::PH_TAG;
				end
			end
			default: begin
			end
		endcase

		rec1.run_end = !final_byte && !burst;

		// The last byte of a buffer closes it and puts the parser back at a tag.
		if (final_byte) begin
			trunc_now = (phase_d != ardp_pkg::PH_TAG) && (phase_d != ardp_pkg::PH_STOP);
			phase_d   = ardp_pkg::PH_TAG;
		end
	end

	assign out_free   = !out_valid_q || out_ready;
	assign in_ready   = (seq_q == ardp_pkg::SQ_RUN) && out_free;
	assign accept     = in_valid && in_ready;
	assign entry_last = ((FILL_W'(rd_idx_q) + FILL_W'(1)) == irq_fill_q);

	always_comb begin
		seq_d      = seq_q;
		rd_idx_d   = rd_idx_q;
		fin_pend_d = fin_pend_q;
		load       = 1'b0;
		load_rec   = rec1;
		rd_en      = 1'b0;
		rd_addr    = rd_idx_q;

		case (seq_q)
			ardp_pkg::SQ_RUN: begin
				if (accept) begin
					if (rec1_vld) begin
						load = 1'b1;
						if (burst) begin
							seq_d      = ardp_pkg::SQ_READ;
							rd_idx_d   = '0;
							fin_pend_d = final_byte;
						end else if (final_byte) begin
							seq_d = ardp_pkg::SQ_DONE;
						end
					end else if (final_byte) begin
						load = 1'b1;
						load_rec = ardp_pkg::mk_rec(ardp_pkg::K_DONE, 7'd0, 16'd0, 8'd0,
							8'd0, 32'd0, 32'd0, trunc_now, 1'b0, 1'b1);
					end
				end
			end
			ardp_pkg::SQ_READ: begin
				rd_en = 1'b1;
				seq_d = ardp_pkg::SQ_ENTRY;
			end
			ardp_pkg::SQ_ENTRY: begin
				if (out_free) begin
					load = 1'b1;
					load_rec = ardp_pkg::mk_rec(ardp_pkg::K_IRQ_ENTRY, cur_item_q, cur_size_q,
						attr_q, count_q, rd_data, 32'd0, 1'b0, 1'b0,
						entry_last && !fin_pend_q);
					if (entry_last) begin
						seq_d = fin_pend_q ? ardp_pkg::SQ_DONE : ardp_pkg::SQ_RUN;
					end else begin
						// Fetch the next entry while this one goes out.
						rd_idx_d = rd_idx_q + IDX_W'(1);
						rd_en    = 1'b1;
						rd_addr  = rd_idx_q + IDX_W'(1);
					end
				end
			end
			ardp_pkg::SQ_DONE: begin
				if (out_free) begin
					// A done record here follows a completed descriptor, so the
					// buffer did not end inside one.
					load = 1'b1;
					load_rec = ardp_pkg::mk_rec(ardp_pkg::K_DONE, 7'd0, 16'd0, 8'd0,
						8'd0, 32'd0, 32'd0, 1'b0, 1'b0, 1'b1);
					seq_d = ardp_pkg::SQ_RUN;
				end
			end
			default: begin
				seq_d = ardp_pkg::SQ_RUN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= ardp_pkg::PH_TAG;
			irq_fill_q  <= '0;
			ovf_q       <= 1'b0;
			seq_q       <= ardp_pkg::SQ_RUN;
			rd_idx_q    <= '0;
			fin_pend_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				phase_q    <= phase_d;
				irq_fill_q <= irq_fill_d;
				ovf_q      <= ovf_d;
			end
			seq_q      <= seq_d;
			rd_idx_q   <= rd_idx_d;
			fin_pend_q <= fin_pend_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_item_q <= cur_item_d;
			cur_size_q <= cur_size_d;
			pos_q      <= pos_d;
			attr_q     <= attr_d;
			count_q    <= count_d;
			base_q     <= base_d;
			span_q     <= span_d;
		end
		if (load) begin
			out_q <= load_rec;
		end
	end

	ardp_irq_store #(
		.DEPTH  (MAX_IRQS),
		.ADDR_W (IDX_W)
	) u_irq_store (
		.clk     (clk),
		.wr_en   (accept && irq_wr_en),
		.wr_addr (irq_fill_q[IDX_W-1:0]),
		.wr_data (irq_wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign out_valid    = out_valid_q;
	assign record_kind  = out_q.kind;
	assign item_code    = out_q.item;
	assign desc_length  = out_q.len;
	assign attr_byte    = out_q.attr;
	assign irq_total    = out_q.count;
	assign word_a       = out_q.word_a;
	assign word_b       = out_q.word_b;
	assign truncated    = out_q.trunc;
	assign irq_overflow = out_q.ovf;
	assign run_end      = out_q.run_end;

	// The fill count never passes the store depth.
	`ARDP_CHECK(a_fill_bound, 1'b1, irq_fill_q <= FILL_W'(MAX_IRQS), "IRQ fill beyond store depth")
	// An entry is only read back from a slot that was filled.
	`ARDP_CHECK(a_entry_in_range, seq_q == ardp_pkg::SQ_ENTRY, FILL_W'(rd_idx_q) < irq_fill_q, "IRQ entry read past fill")
	// A store read is always followed by the entry state that emits its entry.
	`ARDP_CHECK_NEXT(a_read_then_entry, seq_q == ardp_pkg::SQ_READ, seq_q == ardp_pkg::SQ_ENTRY, "store read not followed by entry")

endmodule

// ===== dv/tb.sv =====
// Testbench for acpi_resource_descriptor_parser_core: resource-template bytes in, records out.
// Depends on ardp_pkg for the record kinds, tag constants and the default IRQ store depth.
`timescale 1ns / 1ps

module tb;
	import ardp_pkg::*;

	localparam int NUM_IRQ_SLOTS = MAX_IRQS_DEF;
	localparam int HALF_PERIOD = 6;
	localparam int RESET_CYCLES = 5;
	// Longest quiet stretch after the last record: an IRQ burst plus the done record.
	localparam int DRAIN_CYCLES = 40;
	localparam int RANDOM_WORDS = 100;
	localparam int MAX_REPORTS = 10;
	localparam logic [7:0] LARGE_BIT = 8'h80;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        final_byte;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  record_kind;
	logic [6:0]  item_code;
	logic [15:0] desc_length;
	logic [7:0]  attr_byte;
	logic [7:0]  irq_total;
	logic [31:0] word_a;
	logic [31:0] word_b;
	logic        truncated;
	logic        irq_overflow;
	logic        run_end;

	acpi_resource_descriptor_parser_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.final_byte(final_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.record_kind(record_kind),
		.item_code(item_code),
		.desc_length(desc_length),
		.attr_byte(attr_byte),
		.irq_total(irq_total),
		.word_a(word_a),
		.word_b(word_b),
		.truncated(truncated),
		.irq_overflow(irq_overflow),
		.run_end(run_end)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Parser predictor. It tracks the descriptor being walked and builds the
	// records that each accepted word should produce.
	// ------------------------------------------------------------------
	phase_t      walk_phase;
	logic [6:0]  walk_item;
	logic [15:0] walk_size;
	logic [15:0] walk_pos;
	logic [7:0]  walk_attr;
	logic [7:0]  walk_count;
	logic [31:0] walk_base;
	logic [31:0] walk_span;
	logic [31:0] irq_numbers [NUM_IRQ_SLOTS];
	int          irq_kept;
	logic        irq_dropped;

	rec_t expected_records [$];
	rec_t word_records [$];

	// Shared between the directed tests and the random buffers.
	logic [7:0] buf_bytes [$];
	bit         idle_on = 1'b1;
	int         words_sent = 0;
	int         records_checked = 0;
	int         mismatches = 0;

	// Hard stop well beyond the slowest legal run: every word waiting out the
	// longest sender gap and every record the longest receiver stall.
	initial begin
		#8_000_000;
		$display("timeout: %0d records still expected", expected_records.size());
		$display("tb failed");
		$finish;
	end

	function automatic void add_record(input kind_t kind, input logic [6:0] item,
		input logic [15:0] len, input logic [7:0] attr, input logic [7:0] count,
		input logic [31:0] wa, input logic [31:0] wb, input logic trunc, input logic ovf);
		rec_t r;
		r.kind    = kind;
		r.item    = item;
		r.len     = len;
		r.attr    = attr;
		r.count   = count;
		r.word_a  = wa;
		r.word_b  = wb;
		r.trunc   = trunc;
		r.ovf     = ovf;
		r.run_end = 1'b0;
		word_records.push_back(r);
	endfunction

	function automatic void clear_walk();
		walk_phase  = PH_TAG;
		walk_item   = '0;
		walk_size   = '0;
		walk_pos    = '0;
		walk_attr   = '0;
		walk_count  = '0;
		walk_base   = '0;
		walk_span   = '0;
		irq_kept    = 0;
		irq_dropped = 1'b0;
	endfunction

	function automatic bit is_mem32_shape();
		return walk_item == ITEM_MEM && walk_size == MEM_LEN;
	endfunction

	function automatic bit is_irq_shape();
		return walk_item == ITEM_IRQ && walk_size >= IRQ_MIN_LEN;
	endfunction

	// A complete large descriptor: one Memory32Fixed record, an IRQ header
	// followed by its stored entries, or a bare record for anything else.
	function automatic void close_large();
		if (is_mem32_shape()) begin
			add_record(K_MEM32, walk_item, walk_size, walk_attr, 8'h00,
				walk_base, walk_span, 1'b0, 1'b0);
		end else if (is_irq_shape()) begin
			add_record(K_IRQ_HDR, walk_item, walk_size, walk_attr, walk_count,
				32'h0, 32'h0, 1'b0, irq_dropped);
			for (int j = 0; j < irq_kept; j++)
				add_record(K_IRQ_ENTRY, walk_item, walk_size, walk_attr, walk_count,
					irq_numbers[j], 32'h0, 1'b0, 1'b0);
		end else begin
			add_record(K_UNKNOWN, walk_item, walk_size, 8'h00, 8'h00,
				32'h0, 32'h0, 1'b0, 1'b0);
		end
		walk_phase = PH_TAG;
	endfunction

	function automatic void absorb_payload(input logic [7:0] b);
		int pos;
		int k;
		int j;
		pos = int'(walk_pos);
		if (is_mem32_shape()) begin
			if (pos == 0)
				walk_attr = b;
			else if (pos <= 4)
				walk_base = walk_base | ({24'h0, b} << (8 * (pos - 1)));
			else if (pos <= 8)
				walk_span = walk_span | ({24'h0, b} << (8 * (pos - 5)));
		end else if (is_irq_shape()) begin
			if (pos == 0) begin
				walk_attr = b;
			end else if (pos == 1) begin
				walk_count = b;
			end else begin
				// IRQ numbers are gathered little-endian in the span register;
				// only words whose index is below the count byte are kept.
				k = (pos - 2) & 3;
				j = (pos - 2) >> 2;
				if (k == 0)
					walk_span = {24'h0, b};
				else
					walk_span = walk_span | ({24'h0, b} << (8 * k));
				if (k == 3 && j < int'(walk_count)) begin
					if (irq_kept < NUM_IRQ_SLOTS) begin
						irq_numbers[irq_kept] = walk_span;
						irq_kept++;
					end else begin
						irq_dropped = 1'b1;
					end
				end
			end
		end
	endfunction

	function automatic void predict_records(input logic [7:0] b, input logic fin);
		logic trunc;
		word_records.delete();
		case (walk_phase)
			PH_TAG: begin
				if (b == END_TAG) begin
					add_record(K_END, ITEM_END, 16'd1, 8'h00, 8'h00,
						32'h0, 32'h0, 1'b0, 1'b0);
					walk_phase = PH_STOP;
				end else if (b[7]) begin
					walk_item   = b[6:0];
					walk_size   = '0;
					walk_pos    = '0;
					walk_attr   = '0;
					walk_count  = '0;
					walk_base   = '0;
					walk_span   = '0;
					irq_kept    = 0;
					irq_dropped = 1'b0;
					walk_phase  = PH_LLO;
				end else begin
					walk_item = {3'b000, b[6:3]};
					walk_size = {13'h0, b[2:0]};
					walk_pos  = '0;
					if (walk_size == 16'h0)
						add_record(K_SMALL, walk_item, 16'h0, 8'h00, 8'h00,
							32'h0, 32'h0, 1'b0, 1'b0);
					else
						walk_phase = PH_SPAY;
				end
			end
			PH_LLO: begin
				walk_size  = {8'h00, b};
				walk_phase = PH_LHI;
			end
			PH_LHI: begin
				walk_size = {b, walk_size[7:0]};
				if (walk_size == 16'h0)
					close_large();
				else
					walk_phase = PH_LPAY;
			end
			PH_LPAY: begin
				absorb_payload(b);
				walk_pos = walk_pos + 16'd1;
				if (walk_pos == walk_size)
					close_large();
			end
			PH_SPAY: begin
				walk_pos = walk_pos + 16'd1;
				if (walk_pos >= walk_size) begin
					add_record(K_SMALL, walk_item, walk_size, 8'h00, 8'h00,
						32'h0, 32'h0, 1'b0, 1'b0);
					walk_phase = PH_TAG;
				end
			end
			default: begin
			end
		endcase

		// The last byte of a buffer always closes with a done record and a
		// fresh parser; it is truncated if a descriptor was still open.
		if (fin) begin
			trunc = (walk_phase != PH_TAG && walk_phase != PH_STOP);
			add_record(K_DONE, 7'h00, 16'h0, 8'h00, 8'h00, 32'h0, 32'h0, trunc, 1'b0);
			clear_walk();
		end

		if (word_records.size() > 0)
			word_records[word_records.size() - 1].run_end = 1'b1;
		foreach (word_records[i])
			expected_records.push_back(word_records[i]);
	endfunction

	// ------------------------------------------------------------------
	// Traffic shaping. Gaps are mostly short with an occasional long one;
	// clearing idle_on gives stretches at full rate on both channels.
	// ------------------------------------------------------------------
	function automatic int pick_gap();
		int r;
		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 96)
			return $urandom_range(4, 10);
		else
			return $urandom_range(12, 40);
	endfunction

	// Every task below starts and ends on a falling edge, so each input
	// changes at most once per falling edge.
	task automatic send_word(input logic [7:0] b, input logic fin);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid   <= 1'b1;
		data_byte  <= b;
		final_byte <= fin;
		do
			@(posedge clk);
		while (!in_ready);
		predict_records(b, fin);
		words_sent++;
		@(negedge clk);
	endtask

	// Sends buf_bytes as one buffer, flagging its last byte, then empties it.
	task automatic send_buffer();
		foreach (buf_bytes[i])
			send_word(buf_bytes[i], i == buf_bytes.size() - 1);
		buf_bytes.delete();
	endtask

	task automatic add_word32(input logic [31:0] w);
		buf_bytes.push_back(w[7:0]);
		buf_bytes.push_back(w[15:8]);
		buf_bytes.push_back(w[23:16]);
		buf_bytes.push_back(w[31:24]);
	endtask

	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin : drive_ready
			int stall;
			stall = pick_gap();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
	end

	// ------------------------------------------------------------------
	// Record checker: each accepted record against the oldest expectation.
	// ------------------------------------------------------------------
	function automatic string show_record(input rec_t r);
		return $sformatf({"kind %0d item %02h len %0d attr %02h count %0d a %08h b %08h",
			" tr %0b ov %0b end %0b"},
			r.kind, r.item, r.len, r.attr, r.count, r.word_a, r.word_b,
			r.trunc, r.ovf, r.run_end);
	endfunction

	always @(posedge clk) begin : check_records
		rec_t  got;
		rec_t  want;
		string diffs;
		if (arst_n && out_valid && out_ready) begin
			got.kind    = kind_t'(record_kind);
			got.item    = item_code;
			got.len     = desc_length;
			got.attr    = attr_byte;
			got.count   = irq_total;
			got.word_a  = word_a;
			got.word_b  = word_b;
			got.trunc   = truncated;
			got.ovf     = irq_overflow;
			got.run_end = run_end;
			if (expected_records.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: record with nothing expected: %s",
						$realtime, show_record(got));
			end else begin
				want  = expected_records.pop_front();
				diffs = "";
				if (got.kind !== want.kind)       diffs = {diffs, " record_kind"};
				if (got.item !== want.item)       diffs = {diffs, " item_code"};
				if (got.len !== want.len)         diffs = {diffs, " desc_length"};
				if (got.attr !== want.attr)       diffs = {diffs, " attr_byte"};
				if (got.count !== want.count)     diffs = {diffs, " irq_total"};
				if (got.word_a !== want.word_a)   diffs = {diffs, " word_a"};
				if (got.word_b !== want.word_b)   diffs = {diffs, " word_b"};
				if (got.trunc !== want.trunc)     diffs = {diffs, " truncated"};
				if (got.ovf !== want.ovf)         diffs = {diffs, " irq_overflow"};
				if (got.run_end !== want.run_end) diffs = {diffs, " run_end"};
				if (diffs != "") begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("%0t: mismatch on%s", $realtime, diffs);
						$display("  expected %s", show_record(want));
						$display("  actual   %s", show_record(got));
					end
				end
				records_checked++;
			end
		end
	end

	// ------------------------------------------------------------------
	// Directed tests.
	// ------------------------------------------------------------------

	// Small tags of zero, two and seven payload bytes, then the end tag.
	task automatic test_small_descriptors();
		buf_bytes = '{8'h00, 8'h22, 8'hAA, 8'h55,
			8'h7F, 8'hFF, 8'h00, 8'h80, 8'h01, 8'h7E, 8'h79, 8'hC3,
			END_TAG, 8'h00};
		send_buffer();
	endtask

	// A well-formed Memory32Fixed, then item 6 with a length that is not 9.
	task automatic test_mem32fixed();
		buf_bytes = '{LARGE_BIT | 8'(ITEM_MEM), 8'h09, 8'h00, 8'h01};
		add_word32(32'h1234_5678);
		add_word32(32'hFFFF_FFFF);
		buf_bytes.push_back(LARGE_BIT | 8'(ITEM_MEM));
		buf_bytes.push_back(8'h08);
		buf_bytes.push_back(8'h00);
		add_word32(32'h0);
		add_word32(32'hA5A5_5A5A);
		send_buffer();
	endtask

	// Extended IRQ: a word past the count, a count with no words, a partial
	// trailing word, and a length below the minimum.
	task automatic test_ext_irq();
		buf_bytes = '{LARGE_BIT | 8'(ITEM_IRQ), 8'h0A, 8'h00, 8'h0F, 8'h01};
		add_word32(32'hDEAD_BEEF);
		add_word32(32'h0000_0001);
		buf_bytes.push_back(LARGE_BIT | 8'(ITEM_IRQ));
		buf_bytes.push_back(8'h02);
		buf_bytes.push_back(8'h00);
		buf_bytes.push_back(8'h03);
		buf_bytes.push_back(8'h05);
		buf_bytes.push_back(LARGE_BIT | 8'(ITEM_IRQ));
		buf_bytes.push_back(8'h07);
		buf_bytes.push_back(8'h00);
		buf_bytes.push_back(8'h02);
		buf_bytes.push_back(8'h02);
		add_word32(32'h8000_0020);
		buf_bytes.push_back(8'h11);
		buf_bytes.push_back(LARGE_BIT | 8'(ITEM_IRQ));
		buf_bytes.push_back(8'h01);
		buf_bytes.push_back(8'h00);
		buf_bytes.push_back(8'hAA);
		send_buffer();
	endtask

	// More counted IRQ words than the store holds; the final byte completes
	// the descriptor, so one word yields the largest burst of records.
	task automatic test_irq_store_full();
		int nwords;
		nwords = NUM_IRQ_SLOTS + 2;
		buf_bytes = '{LARGE_BIT | 8'(ITEM_IRQ), 8'(2 + 4 * nwords), 8'h00, 8'hFF, 8'(nwords)};
		for (int i = 0; i < nwords; i++)
			add_word32($urandom());
		send_buffer();
	endtask

	// Large descriptors of length zero complete on the second length byte.
	task automatic test_zero_length();
		buf_bytes = '{8'h8A, 8'h00, 8'h00,
			LARGE_BIT | 8'(ITEM_MEM), 8'h00, 8'h00,
			LARGE_BIT | 8'(ITEM_IRQ), 8'h00, 8'h00};
		send_buffer();
	endtask

	// Everything after the end tag up to the final byte is ignored.
	task automatic test_after_end();
		buf_bytes = '{END_TAG, 8'hFF, LARGE_BIT | 8'(ITEM_MEM), 8'h09, END_TAG};
		send_buffer();
	endtask

	// Buffers cut right after a tag and inside payloads, then two complete one-byte buffers.
	task automatic test_truncation();
		buf_bytes = '{LARGE_BIT | 8'(ITEM_IRQ)};
		send_buffer();
		buf_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h01, 8'h02};
		send_buffer();
		buf_bytes = '{8'h23, 8'h11};
		send_buffer();
		buf_bytes = '{END_TAG};
		send_buffer();
		buf_bytes = '{8'h00};
		send_buffer();
	endtask

	// ------------------------------------------------------------------
	// Random buffers: mostly well-formed descriptor chains with random
	// content, plus truncated buffers and raw noise.
	// ------------------------------------------------------------------
	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [31:0] pick_word32();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 32'h0;
		else if (r == 1)
			return 32'hFFFF_FFFF;
		return $urandom();
	endfunction

	task automatic add_random_small();
		logic [3:0] item;
		logic [2:0] size;
		item = 4'($urandom_range(0, 15));
		size = 3'($urandom_range(0, 7));
		if ({1'b0, item, size} == END_TAG)
			size = 3'd2;
		buf_bytes.push_back({1'b0, item, size});
		repeat (size) buf_bytes.push_back(rand_byte());
	endtask

	task automatic add_random_irq(input bit wrong_length);
		int nwords;
		int extra;
		int len;
		int r;
		logic [7:0] count;
		nwords = ($urandom_range(0, 99) < 15)
			? $urandom_range(NUM_IRQ_SLOTS + 1, NUM_IRQ_SLOTS + 4)
			: $urandom_range(0, 5);
		extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
		r = $urandom_range(0, 9);
		if (r < 4)
			count = 8'(nwords);
		else if (r < 6)
			count = 8'($urandom_range(0, nwords));
		else if (r < 8)
			count = 8'($urandom_range(nwords, 255));
		else if (r == 8)
			count = 8'h00;
		else
			count = 8'hFF;
		len = wrong_length ? $urandom_range(0, 1) : 2 + 4 * nwords + extra;
		buf_bytes.push_back(LARGE_BIT | 8'(ITEM_IRQ));
		buf_bytes.push_back(len[7:0]);
		buf_bytes.push_back(len[15:8]);
		if (wrong_length) begin
			repeat (len) buf_bytes.push_back(rand_byte());
		end else begin
			buf_bytes.push_back(rand_byte());
			buf_bytes.push_back(count);
			repeat (nwords) add_word32(pick_word32());
			repeat (extra) buf_bytes.push_back(rand_byte());
		end
	endtask

	task automatic add_random_mem(input bit wrong_length);
		int len;
		len = wrong_length ? $urandom_range(0, 12) : 9;
		if (wrong_length && len == 9)
			len = 10;
		buf_bytes.push_back(LARGE_BIT | 8'(ITEM_MEM));
		buf_bytes.push_back(len[7:0]);
		buf_bytes.push_back(8'h00);
		repeat (len) buf_bytes.push_back(rand_byte());
	endtask

	task automatic add_random_large();
		int len;
		len = $urandom_range(0, 8);
		buf_bytes.push_back(LARGE_BIT | 8'($urandom_range(0, 127)));
		buf_bytes.push_back(len[7:0]);
		buf_bytes.push_back(8'h00);
		repeat (len) buf_bytes.push_back(rand_byte());
	endtask

	task automatic test_random_buffers();
		int start;
		int pick;
		int ignored;
		int keep;
		start = words_sent;
		while (words_sent - start < RANDOM_WORDS) begin
			idle_on = ($urandom_range(0, 4) != 0);
			ignored = 0;
			if ($urandom_range(0, 19) == 0) begin
				repeat ($urandom_range(1, 10)) buf_bytes.push_back(rand_byte());
			end else begin
				repeat ($urandom_range(1, 4)) begin
					pick = $urandom_range(0, 99);
					if (pick < 25)
						add_random_small();
					else if (pick < 45)
						add_random_mem(1'b0);
					else if (pick < 75)
						add_random_irq(1'b0);
					else if (pick < 80)
						add_random_mem(1'b1);
					else if (pick < 85)
						add_random_irq(1'b1);
					else
						add_random_large();
				end
				if ($urandom_range(0, 9) < 6) begin
					buf_bytes.push_back(END_TAG);
					ignored = $urandom_range(0, 3);
					repeat (ignored) buf_bytes.push_back(rand_byte());
				end
				// Now and then the buffer stops at a random point.
				if ($urandom_range(0, 9) == 0) begin
					keep = $urandom_range(1, buf_bytes.size());
					while (buf_bytes.size() > keep)
						void'(buf_bytes.pop_back());
					ignored = 0;
				end
			end
			send_buffer();
			start = start + ignored;
		end
		idle_on = 1'b1;
	endtask

	// ------------------------------------------------------------------
	// Main sequence.
	// ------------------------------------------------------------------
	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		data_byte  = 8'h00;
		final_byte = 1'b0;
		clear_walk();
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_small_descriptors();
		test_mem32fixed();
		test_ext_irq();
		test_irq_store_full();
		test_zero_length();
		test_after_end();
		test_truncation();
		test_random_buffers();
		in_valid <= 1'b0;

		while (expected_records.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d buffer words: small, Memory32Fixed, Extended IRQ, unknown,",
			words_sent);
		$display("end-tag and truncated descriptors; %0d records checked, %0d mismatches.",
			records_checked, mismatches);
		if (mismatches == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
